>>> rtl/core/chained_hash_table_engine_assert.svh
`ifndef CHAINED_HASH_TABLE_ENGINE_ASSERT_SVH
`define CHAINED_HASH_TABLE_ENGINE_ASSERT_SVH

// same-cycle implication
`define CHTE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("chte assertion failed");

// next-cycle implication
`define CHTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("chte assertion failed");

`endif

>>> rtl/core/chte_pkg.sv
package chte_pkg;

	typedef logic [1:0] mode_t;
	typedef logic [1:0] status_t;

	localparam mode_t MODE_INSERT = 2'd0;
	localparam mode_t MODE_DELETE = 2'd1;
	localparam mode_t MODE_SEARCH = 2'd2;

	localparam status_t STATUS_OK       = 2'd0;
	localparam status_t STATUS_NOTFOUND = 2'd1;
	localparam status_t STATUS_FULL     = 2'd2;

	localparam int COUNT_MAX = 15;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_QUO,
		ST_REM,
		ST_ROW
	} state_t;

endpackage

>>> rtl/core/chained_hash_table_engine.sv
// Multiset hash table. Each bucket (key modulo NUM_BUCKETS) is one row of a
// single RAM holding SLOTS_PER_BUCKET keys and their valid bits. The
// reciprocal multiply for the bucket runs in the accepting cycle. In ST_QUO
// the block subtracts quotient times NUM_BUCKETS from the key. ST_REM
// corrects the remainder and reads the row. ST_ROW compares all slots, writes
// the row back and loads the result register. One item is in flight at a
// time, so a new item is accepted only after the last one has left ST_ROW.
// The result sits in an output register, so the next item is accepted while
// it waits. That item then holds in its compare cycle until the output
// register is free. After reset the block clears the RAM, one row per cycle,
// before accepting its first item.
module chained_hash_table_engine #(
	parameter int NUM_BUCKETS      = 32,
	parameter int SLOTS_PER_BUCKET = 8,
	parameter int KEY_WIDTH        = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  chte_pkg::mode_t   mode,
	input  logic [31:0]       key,
	output logic              out_valid,
	input  logic              out_ready,
	output chte_pkg::status_t status,
	output logic [3:0]        match_count
);

	import chte_pkg::*;

	localparam int BW     = $clog2(NUM_BUCKETS);
	localparam int S      = SLOTS_PER_BUCKET;
	localparam int K      = KEY_WIDTH;
	localparam int ROW_W  = S * (K + 1);
	localparam int CW_RAW = $clog2(S + 1);
	localparam int CW     = (CW_RAW > 4) ? CW_RAW : 4;
	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / NUM_BUCKETS);
	localparam logic [31:0] NB32  = 32'(NUM_BUCKETS);
	localparam logic [BW:0] NB    = (BW + 1)'(NUM_BUCKETS);

	state_t state_q, state_d;

	logic [BW-1:0]   clr_q;
	mode_t           mode_q;
	logic [K-1:0]    key_s1;
	logic [31:0]     quo_s1;
	logic [BW:0]     rem_s2;
	logic [BW-1:0]   bucket_q;

	logic [K-1:0]    key_k;
	logic [31:0]     key32;
	logic [63:0]     prod_quo;
	logic [31:0]     prod_qn;
	logic [BW-1:0]   bucket_c;

	logic            ram_we;
	logic [BW-1:0]   ram_waddr;
	logic [ROW_W-1:0] ram_wdata;
	logic [ROW_W-1:0] ram_rdata;

	logic [S-1:0]    row_valid;
	logic [S-1:0]    match;
	logic [S-1:0]    new_valid;
	logic [S*K-1:0]  new_keys;
	logic            found_free;
	logic [CW-1:0]   cnt;
	status_t         status_c;
	logic [3:0]      count_c;
	logic            row_write;
	logic            load_out;

	function automatic logic [31:0] key32_s1_diff(input logic [K-1:0] k, input logic [31:0] qn);
		logic [31:0] k32;
		k32 = 32'(k);
		return k32 - qn;
	endfunction

	assign key_k    = K'({32'd0, key});
	assign key32    = 32'(key_k);
	assign prod_quo = {32'd0, key32} * {32'd0, RECIP};
	assign prod_qn  = 32'({32'd0, quo_s1} * {32'd0, NB32});
	assign bucket_c = (rem_s2 >= NB) ? BW'(rem_s2 - NB) : rem_s2[BW-1:0];

	chte_ram #(.WIDTH(ROW_W), .DEPTH(NUM_BUCKETS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (bucket_c),
		.rdata (ram_rdata)
	);

	// slot compare and row update
	always_comb begin
		row_valid  = ram_rdata[S*K +: S];
		new_keys   = ram_rdata[S*K-1:0];
		new_valid  = row_valid;
		found_free = 1'b0;
		cnt        = '0;
		for (int i = 0; i < S; i++) begin
			match[i] = row_valid[i] && (ram_rdata[i*K +: K] == key_s1);
			cnt      = cnt + CW'(match[i]);
		end
		count_c = (cnt > CW'(COUNT_MAX)) ? 4'(COUNT_MAX) : cnt[3:0];
		if (mode_q == MODE_INSERT) begin
			for (int i = 0; i < S; i++) begin
				if (!found_free && !row_valid[i]) begin
					found_free        = 1'b1;
					new_valid[i]      = 1'b1;
					new_keys[i*K +: K] = key_s1;
				end
			end
			status_c  = found_free ? STATUS_OK : STATUS_FULL;
			count_c   = 4'd0;
			row_write = found_free;
		end else begin
			status_c  = (cnt != '0) ? STATUS_OK : STATUS_NOTFOUND;
			row_write = 1'b0;
			if (mode_q == MODE_DELETE) begin
				new_valid = row_valid & ~match;
				row_write = |match;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = bucket_q;
		ram_wdata = {new_valid, new_keys};
		load_out  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == BW'(NUM_BUCKETS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_QUO;
				end
			end
			ST_QUO: begin
				state_d = ST_REM;
			end
			ST_REM: begin
				state_d = ST_ROW;
			end
			ST_ROW: begin
				if (!out_valid || out_ready) begin
					ram_we   = row_write;
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + BW'(1);
			end
			if (load_out) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mode_q <= mode;
			key_s1 <= key_k;
			quo_s1 <= prod_quo[63:32];
		end
		if (state_q == ST_QUO) begin
			rem_s2 <= (BW + 1)'(key32_s1_diff(key_s1, prod_qn));
		end
		if (state_q == ST_REM) begin
			bucket_q <= bucket_c;
		end
		if (load_out) begin
			status      <= status_c;
			match_count <= count_c;
		end
	end

endmodule

>>> rtl/core/chte_ram.sv
module chte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/chte_checker.sv
module chte_checker #(
	parameter int SLOTS_PER_BUCKET = 8
) (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input chte_pkg::status_t status,
	input logic [3:0]        match_count
);

	import chte_pkg::*;

	`include "chained_hash_table_engine_assert.svh"

	localparam logic [4:0] MAX_CNT = (SLOTS_PER_BUCKET > COUNT_MAX) ?
		5'(COUNT_MAX) : 5'(SLOTS_PER_BUCKET);

	// stalled result beat holds
	`CHTE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(match_count))
	`CHTE_ASSERT_IMPLY(a_status_code, clk, arst_n, out_valid, status == STATUS_OK || status == STATUS_NOTFOUND || status == STATUS_FULL)
	`CHTE_ASSERT_IMPLY(a_miss_zero, clk, arst_n, out_valid && (status == STATUS_NOTFOUND || status == STATUS_FULL), match_count == 4'd0)
	`CHTE_ASSERT_IMPLY(a_count_bound, clk, arst_n, out_valid, {1'b0, match_count} <= MAX_CNT)

endmodule

bind chained_hash_table_engine chte_checker #(.SLOTS_PER_BUCKET(SLOTS_PER_BUCKET)) u_chte_checker (.*);
